### design/ffa_pkg.sv
`default_nettype none
package ffa_pkg;

	localparam int ADDR_W   = 32;
	localparam int REQ_W    = 13;
	localparam int STATUS_W = 2;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_OOM       = 2'd1,
		ST_NOT_FOUND = 2'd2
	} status_t;

	typedef enum logic [4:0] {
		OP_NOP,
		OP_LOAD,
		OP_RD_IDX,
		OP_STEP,
		OP_HIT_ALLOC,
		OP_HIT_FREE,
		OP_RD_NEXT,
		OP_MERGE,
		OP_RD_UP,
		OP_WR_UP,
		OP_RD_DN,
		OP_WR_DN,
		OP_WR_ALLOC_A,
		OP_WR_ALLOC_B,
		OP_WR_FREE,
		OP_WR_FREE_DEC,
		OP_FAIL_OOM,
		OP_FAIL_NF,
		OP_PUSH
	} op_t;

	typedef struct packed {
		op_t op;
	} cmd_t;

	typedef struct packed {
		logic is_free;   // current request is a free
		logic fit;       // current entry can host the allocate
		logic match;     // current entry payload address equals the target
		logic last;      // current entry is the last table entry
		logic full;      // block table has no spare entry
		logic next_free; // entry just read is marked free
		logic up_done;   // grow shift reached the split point
		logic dn_done;   // shrink shift reached the table end
	} sts_t;

endpackage
`default_nettype wire

### design/ffa_datapath.sv
`default_nettype none
module ffa_datapath #(
	parameter int ARENA_BYTES  = 4096,
	parameter int MAX_BLOCKS   = 256,
	parameter int HEADER_BYTES = 5
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_wr_en,
	input  wire logic [ffa_pkg::ADDR_W-1:0]    cfg_wr_data,
	input  wire logic                          func,
	input  wire logic [ffa_pkg::REQ_W-1:0]     req_size,
	input  wire logic [ffa_pkg::ADDR_W-1:0]    free_addr,
	input  wire ffa_pkg::cmd_t                 cmd,
	output ffa_pkg::sts_t                      sts,
	output logic      [ffa_pkg::ADDR_W-1:0]    addr,
	output logic      [ffa_pkg::STATUS_W-1:0]  status
);
	import ffa_pkg::*;

	localparam int SIZE_W = $clog2(ARENA_BYTES);
	localparam int IDX_W  = $clog2(MAX_BLOCKS);
	localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
	localparam int CMP_W  = ((REQ_W > SIZE_W) ? REQ_W : SIZE_W) + 1;
	localparam int ENT_W  = SIZE_W + 1;
	localparam logic [SIZE_W-1:0] INIT_SIZE = SIZE_W'(ARENA_BYTES - 2 * HEADER_BYTES);

	logic [ENT_W-1:0]  mem_q [MAX_BLOCKS];
	logic [ENT_W-1:0]  rd_q;
	logic [IDX_W-1:0]  rd_addr_q;

	logic [ADDR_W-1:0] base_q;
	logic              func_q;
	logic [REQ_W-1:0]  req_q;
	logic [ADDR_W-1:0] target_q;
	logic [ADDR_W-1:0] at_q;
	logic [IDX_W-1:0]  idx_q;
	logic [IDX_W-1:0]  k_q;
	logic [CNT_W-1:0]  count_q;
	logic              e0_init_q;
	logic [SIZE_W-1:0] rest_q;
	logic [SIZE_W-1:0] msize_q;
	logic [ADDR_W-1:0] res_addr_q;
	status_t           res_status_q;
	logic [ADDR_W-1:0] addr_q;
	status_t           status_q;

	logic              rd_en;
	logic [IDX_W-1:0]  rd_addr;
	logic              wr_en;
	logic [IDX_W-1:0]  wr_addr;
	logic [ENT_W-1:0]  wr_data;

	logic              cur_free;
	logic [SIZE_W-1:0] cur_size;
	logic [IDX_W-1:0]  idx_inc;
	logic [ADDR_W-1:0] pay_addr;

	// entry 0 reads as its reset value until first written
	always_comb begin
		if (rd_addr_q == '0 && e0_init_q) begin
			cur_free = 1'b1;
			cur_size = INIT_SIZE;
		end else begin
			cur_free = rd_q[SIZE_W];
			cur_size = rd_q[SIZE_W-1:0];
		end
	end

	assign idx_inc  = idx_q + IDX_W'(1);
	assign pay_addr = at_q + ADDR_W'(HEADER_BYTES);

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = idx_q;
		wr_en   = 1'b0;
		wr_addr = idx_q;
		wr_data = rd_q;
		case (cmd.op)
			OP_RD_IDX: begin
				rd_en = 1'b1;
			end
			OP_RD_NEXT: begin
				rd_en   = 1'b1;
				rd_addr = idx_inc;
			end
			OP_RD_UP: begin
				rd_en   = 1'b1;
				rd_addr = k_q - IDX_W'(1);
			end
			OP_RD_DN: begin
				rd_en   = 1'b1;
				rd_addr = k_q + IDX_W'(1);
			end
			OP_WR_UP, OP_WR_DN: begin
				wr_en   = 1'b1;
				wr_addr = k_q;
			end
			OP_WR_ALLOC_A: begin
				wr_en   = 1'b1;
				wr_data = {1'b0, SIZE_W'(req_q)};
			end
			OP_WR_ALLOC_B: begin
				wr_en   = 1'b1;
				wr_addr = idx_inc;
				wr_data = {1'b1, rest_q};
			end
			OP_WR_FREE, OP_WR_FREE_DEC: begin
				wr_en   = 1'b1;
				wr_data = {1'b1, msize_q};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q      <= mem_q[rd_addr];
			rd_addr_q <= rd_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q       <= '0;
			func_q       <= 1'b0;
			req_q        <= '0;
			target_q     <= '0;
			at_q         <= '0;
			idx_q        <= '0;
			k_q          <= '0;
			count_q      <= CNT_W'(1);
			e0_init_q    <= 1'b1;
			rest_q       <= '0;
			msize_q      <= '0;
			res_addr_q   <= '0;
			res_status_q <= ST_OK;
			addr_q       <= '0;
			status_q     <= ST_OK;
		end else begin
			if (cfg_wr_en) begin
				base_q <= cfg_wr_data;
			end
			if (wr_en && wr_addr == '0) begin
				e0_init_q <= 1'b0;
			end
			case (cmd.op)
				OP_LOAD: begin
					func_q   <= func;
					req_q    <= req_size;
					target_q <= free_addr;
					at_q     <= base_q;
					idx_q    <= '0;
				end
				OP_STEP: begin
					at_q  <= pay_addr + ADDR_W'(cur_size);
					idx_q <= idx_inc;
				end
				OP_HIT_ALLOC: begin
					k_q    <= IDX_W'(count_q);
					rest_q <= SIZE_W'(CMP_W'(cur_size) - CMP_W'(req_q) - CMP_W'(HEADER_BYTES));
				end
				OP_HIT_FREE: begin
					msize_q <= cur_size;
				end
				OP_MERGE: begin
					msize_q <= msize_q + cur_size + SIZE_W'(HEADER_BYTES);
					k_q     <= idx_inc;
				end
				OP_WR_UP: begin
					k_q <= k_q - IDX_W'(1);
				end
				OP_WR_DN: begin
					k_q <= k_q + IDX_W'(1);
				end
				OP_WR_ALLOC_B: begin
					count_q      <= count_q + CNT_W'(1);
					res_addr_q   <= pay_addr;
					res_status_q <= ST_OK;
				end
				OP_WR_FREE: begin
					res_addr_q   <= '0;
					res_status_q <= ST_OK;
				end
				OP_WR_FREE_DEC: begin
					count_q      <= count_q - CNT_W'(1);
					res_addr_q   <= '0;
					res_status_q <= ST_OK;
				end
				OP_FAIL_OOM: begin
					res_addr_q   <= '0;
					res_status_q <= ST_OOM;
				end
				OP_FAIL_NF: begin
					res_addr_q   <= '0;
					res_status_q <= ST_NOT_FOUND;
				end
				OP_PUSH: begin
					addr_q   <= res_addr_q;
					status_q <= res_status_q;
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		sts.is_free   = func_q;
		sts.fit       = cur_free &&
			(CMP_W'(req_q) + CMP_W'(HEADER_BYTES) < CMP_W'(cur_size));
		sts.match     = (pay_addr == target_q);
		sts.last      = (CNT_W'(idx_q) + CNT_W'(1) == count_q);
		sts.full      = (count_q == CNT_W'(MAX_BLOCKS));
		sts.next_free = cur_free;
		sts.up_done   = (k_q == idx_inc);
		sts.dn_done   = (CNT_W'(k_q) + CNT_W'(1) == count_q);
	end

	assign addr   = addr_q;
	assign status = status_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != '0 && count_q <= CNT_W'(MAX_BLOCKS))
		else $error("block count out of range");

	a_split_grows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_WR_ALLOC_B |=> count_q == $past(count_q) + CNT_W'(1))
		else $error("split did not add a table entry");

	a_e0_written: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(e0_init_q) |-> $past(wr_en && wr_addr == '0))
		else $error("entry 0 left its reset value without a write");

endmodule
`default_nettype wire

### design/ffa_ctrl.sv
`default_nettype none
module ffa_ctrl (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   in_valid,
	output logic        in_stall,
	output logic        out_valid,
	input  wire logic   out_stall,
	input  wire ffa_pkg::sts_t sts,
	output ffa_pkg::cmd_t cmd
);
	import ffa_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_RD,
		S_EV,
		S_NRD,
		S_NEV,
		S_FWR,
		S_DN,
		S_DN_WR,
		S_UP,
		S_UP_WR,
		S_ALB,
		S_FIN
	} state_t;

	state_t state_q;
	state_t nxt;
	logic   out_valid_q;

	always_comb begin
		nxt    = state_q;
		cmd.op = OP_NOP;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.op = OP_LOAD;
					nxt    = S_RD;
				end
			end
			S_RD: begin
				cmd.op = OP_RD_IDX;
				nxt    = S_EV;
			end
			S_EV: begin
				if (sts.is_free) begin
					if (sts.match) begin
						cmd.op = OP_HIT_FREE;
						nxt    = sts.last ? S_FWR : S_NRD;
					end else if (sts.last) begin
						cmd.op = OP_FAIL_NF;
						nxt    = S_FIN;
					end else begin
						cmd.op = OP_STEP;
						nxt    = S_RD;
					end
				end else if (sts.fit) begin
					cmd.op = sts.full ? OP_FAIL_OOM : OP_HIT_ALLOC;
					nxt    = sts.full ? S_FIN : S_UP;
				end else if (sts.last) begin
					cmd.op = OP_FAIL_OOM;
					nxt    = S_FIN;
				end else begin
					cmd.op = OP_STEP;
					nxt    = S_RD;
				end
			end
			S_NRD: begin
				cmd.op = OP_RD_NEXT;
				nxt    = S_NEV;
			end
			S_NEV: begin
				cmd.op = sts.next_free ? OP_MERGE : OP_WR_FREE;
				nxt    = sts.next_free ? S_DN : S_FIN;
			end
			S_FWR: begin
				cmd.op = OP_WR_FREE;
				nxt    = S_FIN;
			end
			S_DN: begin
				cmd.op = sts.dn_done ? OP_WR_FREE_DEC : OP_RD_DN;
				nxt    = sts.dn_done ? S_FIN : S_DN_WR;
			end
			S_DN_WR: begin
				cmd.op = OP_WR_DN;
				nxt    = S_DN;
			end
			S_UP: begin
				cmd.op = sts.up_done ? OP_WR_ALLOC_A : OP_RD_UP;
				nxt    = sts.up_done ? S_ALB : S_UP_WR;
			end
			S_UP_WR: begin
				cmd.op = OP_WR_UP;
				nxt    = S_UP;
			end
			S_ALB: begin
				cmd.op = OP_WR_ALLOC_B;
				nxt    = S_FIN;
			end
			S_FIN: begin
				// hold the result until the output register frees up
				if (!out_valid_q || !out_stall) begin
					cmd.op = OP_PUSH;
					nxt    = S_IDLE;
				end
			end
			default: begin
				nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= nxt;
			if (cmd.op == OP_PUSH) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

### design/first_fit_heap_allocator_core.sv
`default_nettype none
// channel | signals                                   | dir
// cfg     | cfg_wr_en, cfg_wr_data (arena base)       | in
// in      | in_valid, in_stall, func, req_size, free_addr | in
// out     | out_valid, out_stall, addr, status        | out
//
// A request takes an accept step, then walks the block table one entry at a
// time (memory read, then evaluate) until it finds a hit or fails. A split or
// merge then shifts the table tail through the block table, a read and then a
// write per moved entry; the request then finishes after any wait for the
// output register.
// Reset restores one free block; no clearing pass is needed.
// Input is taken only between requests; a finished word waits in the output
// register while the next request is accepted and worked on.
module first_fit_heap_allocator_core #(
	parameter int ARENA_BYTES  = 4096,
	parameter int MAX_BLOCKS   = 256,
	parameter int HEADER_BYTES = 5
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_wr_en,
	input  wire logic [ffa_pkg::ADDR_W-1:0]    cfg_wr_data,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic                          func,
	input  wire logic [ffa_pkg::REQ_W-1:0]     req_size,
	input  wire logic [ffa_pkg::ADDR_W-1:0]    free_addr,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic      [ffa_pkg::ADDR_W-1:0]    addr,
	output logic      [ffa_pkg::STATUS_W-1:0]  status
);
	import ffa_pkg::*;

	cmd_t cmd;
	sts_t sts;

	ffa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	ffa_datapath #(
		.ARENA_BYTES  (ARENA_BYTES),
		.MAX_BLOCKS   (MAX_BLOCKS),
		.HEADER_BYTES (HEADER_BYTES)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.func        (func),
		.req_size    (req_size),
		.free_addr   (free_addr),
		.cmd         (cmd),
		.sts         (sts),
		.addr        (addr),
		.status      (status)
	);

endmodule
`default_nettype wire
